// ===== rtl/ualu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the register ALU executor.
// No dependencies; imported by every module of the block.
package ualu_pkg;

  localparam int WORD_W    = 32;
  localparam int OPND_W    = 28;
  localparam int OPC_W     = 3;
  localparam int IDX_W     = 3;
  localparam int REG_COUNT = 8;
  localparam int IMM_W     = 25;
  localparam int CNT_W     = $clog2(WORD_W);

  // Instruction codes; the two remaining 3-bit codes are ignored.
  typedef enum logic [OPC_W-1:0] {
    OP_CMOV = 3'd0,
    OP_ADD  = 3'd1,
    OP_MUL  = 3'd2,
    OP_DIV  = 3'd3,
    OP_NAND = 3'd4,
    OP_LOAD = 3'd5
  } op_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_DIV,
    S_WRITE,
    S_READA
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic rd_src;
    logic exec;
    logic div_start;
    logic take_quo;
    logic wr_reg;
    logic rd_a;
  } ualu_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_nz;
    logic div_done;
  } ualu_sts_t;

endpackage

// ===== rtl/um_register_alu_executor.sv =====
`timescale 1ns / 1ps
// Register ALU executor of an eight-register 32-bit machine.
// Each input transfer carries one instruction: a 3-bit opcode and 28 operand bits.
// Each instruction yields exactly one result transfer: the destination index,
// the value that register holds afterwards, a written flag and a divide-by-zero flag.
// Both channels use valid/ready; in_ready is high only while the controller is idle.
// An item runs read, execute, write and result-load steps; a divide with a
// nonzero divisor adds a divide step after execute, in which the radix-2
// divider produces the quotient one bit per iteration.
// Items are handled one at a time; the next item is accepted while a finished
// result still waits in the output register.
// When the receiver stalls, the result stays in the output register and the
// next instruction proceeds until it needs that register, then waits there.
// Reset (rst_n low, synchronous) empties the output, returns the controller to
// idle and makes every register of the file read as zero through valid bits.
// Depends on ualu_pkg, ualu_controller, ualu_datapath and ualu_divider.
module um_register_alu_executor
  import ualu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [OPND_W-1:0] in_operand_bits,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [IDX_W-1:0]  out_dest_reg,
  output logic [WORD_W-1:0] out_dest_value,
  output logic              out_wrote,
  output logic              out_div_zero
);

  ualu_cmd_t cmd;
  ualu_sts_t sts;

  // Sequencer.
  ualu_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Register file, ALU and divider.
  ualu_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_opcode       (in_opcode),
    .in_operand_bits (in_operand_bits),
    .out_dest_reg    (out_dest_reg),
    .out_dest_value  (out_dest_value),
    .out_wrote       (out_wrote),
    .out_div_zero    (out_div_zero)
  );

endmodule

// ===== rtl/ualu_divider.sv =====
`timescale 1ns / 1ps
// Radix-2 restoring divider for 32-bit unsigned operands, one quotient bit per cycle.
// Depends on ualu_pkg for the word width.
module ualu_divider
  import ualu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [WORD_W-1:0] divisor,
  output logic              done,
  output logic [WORD_W-1:0] quotient
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [WORD_W-1:0] q_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] d_r;
  logic [WORD_W:0]   trial;
  logic [WORD_W-1:0] rem_nxt;
  logic              qbit;

  // One trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    trial = {rem_r, q_r[WORD_W-1]} - {1'b0, d_r};
    if (!trial[WORD_W]) begin
      rem_nxt = trial[WORD_W-1:0];
      qbit    = 1'b1;
    end else begin
      rem_nxt = {rem_r[WORD_W-2:0], q_r[WORD_W-1]};
      qbit    = 1'b0;
    end
  end

  // Control flags: busy for the whole iteration, done for one cycle after it.
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_nxt = 1'b0;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  // Operand and iteration registers.
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
      cnt_r <= CNT_W'(WORD_W - 1);
    end else if (busy_r) begin
      q_r   <= {q_r[WORD_W-2:0], qbit};
      rem_r <= rem_nxt;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// ===== rtl/ualu_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: instruction register, register file, ALU, divider and result register.
// Depends on ualu_pkg and ualu_divider.
module ualu_datapath
  import ualu_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ualu_cmd_t         cmd,
  output ualu_sts_t         sts,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [OPND_W-1:0] in_operand_bits,
  output logic [IDX_W-1:0]  out_dest_reg,
  output logic [WORD_W-1:0] out_dest_value,
  output logic              out_wrote,
  output logic              out_div_zero
);

  logic [OPC_W-1:0]     op_r;
  logic [OPND_W-1:0]    opnd_r;
  logic [WORD_W-1:0]    mem_r [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic [WORD_W-1:0]    bv_r, cv_r;
  logic [WORD_W-1:0]    res_r, res_nxt;
  logic                 wr_r, wr_nxt;
  logic                 dz_r, dz_nxt;
  logic [IDX_W-1:0]     ra, rb, rc;
  logic [2*WORD_W-1:0]  product;
  logic                 div_done;
  logic [WORD_W-1:0]    quotient;
  logic [IDX_W-1:0]     dest_reg_r;
  logic [WORD_W-1:0]    dest_value_r;
  logic                 wrote_r, div_zero_r;

  // Operand fields; load value puts its destination in the top bits.
  assign ra = (op_r == OP_LOAD) ? opnd_r[OPND_W-1 -: IDX_W] : opnd_r[2*IDX_W +: IDX_W];
  assign rb = opnd_r[IDX_W +: IDX_W];
  assign rc = opnd_r[0 +: IDX_W];

  // Instruction register, taken on an input transfer.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_opcode;
      opnd_r <= in_operand_bits;
    end
  end

  // Registered source reads of B and C.
  // Entries never written since reset read as zero.
  always_ff @(posedge clk) begin
    if (cmd.rd_src) begin
      bv_r <= vld_r[rb] ? mem_r[rb] : '0;
      cv_r <= vld_r[rc] ? mem_r[rc] : '0;
    end
  end

  // ALU for everything but the quotient, which the divider supplies.
  always_comb begin
    product = bv_r * cv_r;
    res_nxt = '0;
    wr_nxt  = 1'b0;
    dz_nxt  = 1'b0;
    case (op_t'(op_r))
      OP_CMOV: begin
        res_nxt = bv_r;
        wr_nxt  = (cv_r != '0);
      end
      OP_ADD: begin
        res_nxt = bv_r + cv_r;
        wr_nxt  = 1'b1;
      end
      OP_MUL: begin
        res_nxt = product[WORD_W-1:0];
        wr_nxt  = 1'b1;
      end
      OP_DIV: begin
        wr_nxt = (cv_r != '0);
        dz_nxt = (cv_r == '0);
      end
      OP_NAND: begin
        res_nxt = ~(bv_r & cv_r);
        wr_nxt  = 1'b1;
      end
      OP_LOAD: begin
        res_nxt = WORD_W'(opnd_r[IMM_W-1:0]);
        wr_nxt  = 1'b1;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // Result register; the quotient overwrites it when the divider finishes.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_r <= res_nxt;
      wr_r  <= wr_nxt;
      dz_r  <= dz_nxt;
    end else if (cmd.take_quo) begin
      res_r <= quotient;
    end
  end

  ualu_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (bv_r),
    .divisor  (cv_r),
    .done     (div_done),
    .quotient (quotient)
  );

  // Register file write port.
  always_ff @(posedge clk) begin
    if (cmd.wr_reg && wr_r) begin
      mem_r[ra] <= res_r;
    end
  end

  // Per-entry valid bits stand for the all-zero reset of the file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.wr_reg && wr_r) begin
      vld_r[ra] <= 1'b1;
    end
  end

  // Output register, loaded with the final value of A.
  always_ff @(posedge clk) begin
    if (cmd.rd_a) begin
      dest_reg_r   <= ra;
      dest_value_r <= vld_r[ra] ? mem_r[ra] : '0;
      wrote_r      <= wr_r;
      div_zero_r   <= dz_r;
    end
  end

  assign sts.div_nz   = (op_r == OP_DIV) && (cv_r != '0);
  assign sts.div_done = div_done;

  assign out_dest_reg   = dest_reg_r;
  assign out_dest_value = dest_value_r;
  assign out_wrote      = wrote_r;
  assign out_div_zero   = div_zero_r;

endmodule

// ===== rtl/ualu_controller.sv =====
`timescale 1ns / 1ps
// Controller state machine: sequences read, execute, divide, write and result load.
// Depends on ualu_pkg for the state and command types.
module ualu_controller
  import ualu_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ualu_sts_t sts,
  output ualu_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // State and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        cmd.rd_src = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.div_nz) begin
          cmd.div_start = 1'b1;
          state_nxt     = S_DIV;
        end else begin
          state_nxt = S_WRITE;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.take_quo = 1'b1;
          state_nxt    = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.wr_reg = 1'b1;
        state_nxt  = S_READA;
      end
      S_READA: begin
        // Load the output register once the previous result has left.
        if (!out_valid_r || out_ready) begin
          cmd.rd_a      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/ualu_checker.sv =====
`timescale 1ns / 1ps
// Port-level assertions for the register ALU executor, bound to the top level.
// Depends on ualu_pkg for field widths.
module ualu_checker
  import ualu_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [IDX_W-1:0]  out_dest_reg,
  input logic [WORD_W-1:0] out_dest_value,
  input logic              out_wrote,
  input logic              out_div_zero
);

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dest_reg)
      && $stable(out_dest_value) && $stable(out_wrote) && $stable(out_div_zero))
    else $error("stalled result changed");

  // A skipped divide never reports a write.
  a_dz_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_div_zero && out_wrote))
    else $error("divide by zero reported a write");

  // One instruction at a time: no input transfer right after another.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  // Reset leaves the result channel empty and the input open.
  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the channels");

endmodule

bind um_register_alu_executor ualu_checker u_ualu_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_dest_reg   (out_dest_reg),
  .out_dest_value (out_dest_value),
  .out_wrote      (out_wrote),
  .out_div_zero   (out_div_zero)
);

// ===== dv/tb_um_register_alu_executor.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the register ALU executor of the eight-register machine.
// Depends on ualu_pkg and um_register_alu_executor; a behavioral register-file model
// predicts every result transfer, and a monitor compares results in order.
module tb_um_register_alu_executor;
  import ualu_pkg::*;

  // The two instruction codes that the block ignores.
  localparam logic [OPC_W-1:0] OP_UNDEF_6 = 3'd6;
  localparam logic [OPC_W-1:0] OP_UNDEF_7 = 3'd7;

  // Operand field positions.
  localparam int A_LSB = 6;
  localparam int B_LSB = 3;
  localparam int C_LSB = 0;

  // Cycles to let pass after the last result.
  localparam int SETTLE_CYCLES = 50;
  localparam int STALL_MAX     = 16;
  localparam int LONG_HOLD     = 300;

  typedef struct packed {
    logic [IDX_W-1:0]  dest_reg;
    logic [WORD_W-1:0] dest_value;
    logic              wrote;
    logic              div_zero;
  } alu_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [OPC_W-1:0]  in_opcode = '0;
  logic [OPND_W-1:0] in_operand_bits = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [IDX_W-1:0]  out_dest_reg;
  logic [WORD_W-1:0] out_dest_value;
  logic              out_wrote;
  logic              out_div_zero;

  // Architectural registers as the testbench sees them, and pending results.
  logic [WORD_W-1:0] arch_regs [REG_COUNT];
  alu_result_t       pending_results_q[$];

  // Idle control shared between the test sequence and the two sides.
  bit send_idle_en = 1'b1;
  bit recv_idle_en = 1'b1;
  int hold_req     = 0;

  int n_sent         = 0;
  int n_checked      = 0;
  int n_errors       = 0;
  int n_div          = 0;
  int n_div_zero     = 0;
  int n_cmov_skip    = 0;
  int n_undef        = 0;
  int n_input_stall  = 0;

  um_register_alu_executor u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_opcode       (in_opcode),
    .in_operand_bits (in_operand_bits),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_dest_reg    (out_dest_reg),
    .out_dest_value  (out_dest_value),
    .out_wrote       (out_wrote),
    .out_div_zero    (out_div_zero)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Executes one instruction on the model registers and returns its result.
  function automatic alu_result_t predict_instr(input logic [OPC_W-1:0]  opc,
                                                input logic [OPND_W-1:0] bits);
    alu_result_t       res;
    logic [IDX_W-1:0]  ra;
    logic [WORD_W-1:0] bv;
    logic [WORD_W-1:0] cv;
    logic [WORD_W-1:0] val;
    logic              wr;
    logic              dz;
    ra  = bits[A_LSB +: IDX_W];
    bv  = arch_regs[bits[B_LSB +: IDX_W]];
    cv  = arch_regs[bits[C_LSB +: IDX_W]];
    val = '0;
    wr  = 1'b0;
    dz  = 1'b0;
    case (opc)
      OP_CMOV: begin
        if (cv != '0) begin
          val = bv;
          wr  = 1'b1;
        end else begin
          n_cmov_skip++;
        end
      end
      OP_ADD: begin
        val = bv + cv;
        wr  = 1'b1;
      end
      OP_MUL: begin
        val = bv * cv;
        wr  = 1'b1;
      end
      OP_DIV: begin
        n_div++;
        if (cv == '0) begin
          dz = 1'b1;
          n_div_zero++;
        end else begin
          val = bv / cv;
          wr  = 1'b1;
        end
      end
      OP_NAND: begin
        val = ~(bv & cv);
        wr  = 1'b1;
      end
      OP_LOAD: begin
        ra  = bits[IMM_W +: IDX_W];
        val = {{(WORD_W-IMM_W){1'b0}}, bits[IMM_W-1:0]};
        wr  = 1'b1;
      end
      default: begin
        n_undef++;
      end
    endcase
    // Sources were read above, so A may alias B or C.
    if (wr) arch_regs[ra] = val;
    res.dest_reg   = ra;
    res.dest_value = arch_regs[ra];
    res.wrote      = wr;
    res.div_zero   = dz;
    return res;
  endfunction

  function automatic logic [OPND_W-1:0] reg_fields(input logic [IDX_W-1:0] a,
                                                   input logic [IDX_W-1:0] b,
                                                   input logic [IDX_W-1:0] c);
    return {{(OPND_W-3*IDX_W){1'b0}}, a, b, c};
  endfunction

  function automatic logic [OPND_W-1:0] load_fields(input logic [IDX_W-1:0] a,
                                                    input logic [IMM_W-1:0] imm);
    return {a, imm};
  endfunction

  // Offers one instruction after a random gap, if enabled, and waits for its transfer.
  // Valid stays high on return so that a following item can go back to back.
  task automatic send_instr(input logic [OPC_W-1:0] opc, input logic [OPND_W-1:0] bits);
    int gap;
    gap = send_idle_en ? $urandom_range(0, STALL_MAX) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= opc;
    in_operand_bits <= bits;
    do @(posedge clk); while (!in_ready);
    pending_results_q.push_back(predict_instr(opc, bits));
    n_sent++;
  endtask

  // Lowers valid and waits until every pending result has been checked.
  task automatic wait_all_results();
    in_valid <= 1'b0;
    while (pending_results_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_random_instr();
    int unsigned       pick;
    logic [OPC_W-1:0]  opc;
    logic [OPND_W-1:0] bits;
    pick = $urandom_range(0, 15);
    bits = OPND_W'($urandom());
    case (pick)
      0, 1, 2: begin
        opc = OP_LOAD;
        // Small immediates make small divisors and zero tests more likely.
        if (pick == 0) bits[IMM_W-1:0] = IMM_W'($urandom_range(0, 15));
      end
      3, 4:       opc = OP_CMOV;
      5, 6:       opc = OP_ADD;
      7, 8:       opc = OP_MUL;
      9, 10, 11:  opc = OP_DIV;
      12, 13:     opc = OP_NAND;
      14:         opc = OP_UNDEF_6;
      default:    opc = OP_UNDEF_7;
    endcase
    send_instr(opc, bits);
  endtask

  // Field extremes, every instruction and the corner cases of each.
  task automatic test_directed_cases();
    send_instr(OP_LOAD, load_fields(3'd0, 25'h1FFFFFF));
    send_instr(OP_LOAD, load_fields(3'd7, 25'h0));
    send_instr(OP_LOAD, load_fields(3'd1, 25'd7));
    send_instr(OP_LOAD, load_fields(3'd2, 25'd2));
    send_instr(OP_NAND, reg_fields(3'd3, 3'd7, 3'd7));   // all ones
    send_instr(OP_ADD,  reg_fields(3'd4, 3'd3, 3'd1));   // add wraps
    send_instr(OP_MUL,  reg_fields(3'd5, 3'd3, 3'd3));   // multiply wraps to one
    send_instr(OP_MUL,  reg_fields(3'd6, 3'd0, 3'd0));
    send_instr(OP_DIV,  reg_fields(3'd4, 3'd0, 3'd1));   // floor
    send_instr(OP_DIV,  reg_fields(3'd6, 3'd3, 3'd5));   // largest by one
    send_instr(OP_DIV,  reg_fields(3'd2, 3'd0, 3'd7));   // zero divisor
    send_instr(OP_DIV,  reg_fields(3'd1, 3'd7, 3'd2));   // zero dividend
    send_instr(OP_DIV,  reg_fields(3'd5, 3'd2, 3'd3));   // small by large
    send_instr(OP_CMOV, reg_fields(3'd7, 3'd0, 3'd2));   // move taken
    send_instr(OP_CMOV, reg_fields(3'd3, 3'd0, 3'd1));   // move not taken
    send_instr(OP_UNDEF_6, {OPND_W{1'b1}});
    send_instr(OP_UNDEF_7, {OPND_W{1'b0}});
    send_instr(OP_ADD,  reg_fields(3'd0, 3'd0, 3'd0));   // A, B and C alias
    send_instr(OP_NAND, reg_fields(3'd2, 3'd2, 3'd2));
    send_instr(OP_DIV,  reg_fields(3'd3, 3'd3, 3'd3));
    send_instr(OP_CMOV, reg_fields(3'd5, 3'd4, 3'd5));
    send_instr(OP_LOAD, load_fields(3'd7, 25'h1555555));
    // Unused upper bits set on a register instruction.
    send_instr(OP_ADD,  {{(OPND_W-3*IDX_W){1'b1}}, 3'd1, 3'd2, 3'd3});
    wait_all_results();
  endtask

  task automatic test_random_mix(input int count);
    repeat (count) send_random_instr();
    wait_all_results();
  endtask

  // No gaps on either side, so items follow each other at full rate.
  task automatic test_back_to_back(input int count);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    test_random_mix(count);
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
  endtask

  // The receiver holds off after the first result while the sender keeps
  // offering items, so the output register fills and the input stalls.
  task automatic test_output_stall();
    send_idle_en = 1'b0;
    hold_req     = LONG_HOLD;
    repeat (12) send_random_instr();
    wait_all_results();
    send_idle_en = 1'b1;
  endtask

  // The sender pauses after each short burst until every result is back.
  task automatic test_pause_until_empty();
    repeat (4) begin
      repeat (5) send_random_instr();
      wait_all_results();
    end
  endtask

  // Receiver: draws a stall per result, or serves a requested long hold.
  initial begin
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req > 0) begin
        stall    = hold_req;
        hold_req = 0;
      end else begin
        stall = recv_idle_en ? $urandom_range(0, STALL_MAX) : 0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Result checker: each result transfer is compared with the oldest prediction.
  initial begin
    alu_result_t got;
    alu_result_t want;
    forever begin
      @(posedge clk);
      if (rst_n) begin
        if (in_valid && !in_ready) n_input_stall++;
        if (out_valid && out_ready) begin
          got = {out_dest_reg, out_dest_value, out_wrote, out_div_zero};
          if (pending_results_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result reg=%0d value=%h wrote=%b div_zero=%b",
                     $time, got.dest_reg, got.dest_value, got.wrote, got.div_zero);
          end else begin
            want = pending_results_q.pop_front();
            n_checked++;
            if (got !== want) begin
              n_errors++;
              $display({"%0t: mismatch: expected reg=%0d value=%h wrote=%b div_zero=%b,",
                        " actual reg=%0d value=%h wrote=%b div_zero=%b"},
                       $time, want.dest_reg, want.dest_value, want.wrote, want.div_zero,
                       got.dest_reg, got.dest_value, got.wrote, got.div_zero);
            end
          end
        end
      end
    end
  end

  // Test sequence.
  initial begin
    foreach (arch_regs[i]) arch_regs[i] = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_mix(355);
    test_back_to_back(100);
    test_output_stall();
    test_pause_until_empty();
    test_random_mix(40);
    wait_all_results();
    if (pending_results_q.size() != 0) n_errors++;
    $display("Ran %0d instructions, checked %0d results, %0d mismatches.",
             n_sent, n_checked, n_errors);
    $display({"Divides %0d (zero divisor %0d), skipped moves %0d, ignored codes %0d,",
              " %0d input stall cycles."},
             n_div, n_div_zero, n_cmov_skip, n_undef, n_input_stall);
    if (n_errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
